FILE: rtl/core/sph_cubic_spline_kernel_unit_assert.svh
// ----------------------------------------------------------------------------
// SPH kernel assertion macros
// Short forms for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SPH_CUBIC_SPLINE_KERNEL_UNIT_ASSERT_SVH
`define SPH_CUBIC_SPLINE_KERNEL_UNIT_ASSERT_SVH

// same-cycle implication
`define SPHK_ASSERT_NOW(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPHK_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sphk_pkg.sv
// ----------------------------------------------------------------------------
// sphk_pkg
// Shared constants and the per-word pipeline tag of the SPH kernel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sphk_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int H_W           = 31;
  localparam int Q_BITS        = 31;

  // round(2^32 * 10 / (7 pi))
  localparam logic [30:0] SIGMA_Q32 = 31'd1953043645;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [31:0] TWO_Q30   = 32'h8000_0000;

  typedef struct packed {
    logic        valid;
    logic        outside;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] rlen;
  } sphk_meta_t;

endpackage

`default_nettype wire

FILE: rtl/core/sphk_disp_if.sv
// ----------------------------------------------------------------------------
// sphk_disp_if
// Displacement word channel: valid/ready with dx, dy.
// ----------------------------------------------------------------------------
`default_nettype none

interface sphk_disp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dx;
  logic signed [31:0] dy;

  modport source (output valid, output dx, output dy, input ready);
  modport sink   (input valid, input dx, input dy, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sphk_kern_if.sv
// ----------------------------------------------------------------------------
// sphk_kern_if
// Kernel result word channel: valid/ready with W and its gradient.
// ----------------------------------------------------------------------------
`default_nettype none

interface sphk_kern_if;
  logic               valid;
  logic               ready;
  logic        [30:0] kernel_value;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;

  modport source (output valid, output kernel_value, output grad_x, output grad_y,
                  input ready);
  modport sink   (input valid, input kernel_value, input grad_x, input grad_y,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sphk_isqrt.sv
// ----------------------------------------------------------------------------
// sphk_isqrt
// 32-stage pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sphk_isqrt import sphk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [63:0] rad,
  input  sphk_meta_t  meta_in,
  output sphk_meta_t  meta_out
);

  localparam int STAGES = 32;

  logic [34:0] rem  [STAGES];
  logic [31:0] root [STAGES];
  logic [63:0] rd   [STAGES];
  sphk_meta_t  mm   [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [34:0] rem_p;
    logic [31:0] root_p;
    logic [63:0] rd_p;
    sphk_meta_t  m_p;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rd_p   = rad;
      assign m_p    = meta_in;
    end else begin : g_rest
      assign rem_p  = rem[k-1];
      assign root_p = root[k-1];
      assign rd_p   = rd[k-1];
      assign m_p    = mm[k-1];
    end

    // remainder never exceeds 2*root, so its top two bits are zero here
    assign rem_sh = {rem_p[32:0], rd_p[63:62]};
    assign trial  = {1'b0, root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        mm[k].valid <= 1'b0;
      end else if (en) begin
        mm[k] <= m_p;
        rd[k] <= {rd_p[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem[k]  <= rem_sh - trial;
          root[k] <= {root_p[30:0], 1'b1};
        end else begin
          rem[k]  <= rem_sh;
          root[k] <= {root_p[30:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    meta_out      = mm[STAGES-1];
    meta_out.rlen = root[STAGES-1];
  end

endmodule

`default_nettype wire

FILE: rtl/core/sphk_div.sv
// ----------------------------------------------------------------------------
// sphk_div
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sphk_div import sphk_pkg::*; #(
  parameter int W  = 62,
  parameter int QB = Q_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  sphk_meta_t    meta_in,
  output sphk_meta_t    meta_out,
  output logic [QB-1:0] quo,
  output logic          sat
);

  localparam int XW = W + QB;

  logic [W-1:0]  r  [QB+1];
  logic [W-1:0]  dd [QB+1];
  logic [QB-1:0] qq [QB+1];
  logic          ss [QB+1];
  sphk_meta_t    mm [QB+1];

  // stage 0: overflow check, quotient would need more than QB bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mm[0].valid <= 1'b0;
    end else if (en) begin
      mm[0] <= meta_in;
      r[0]  <= num;
      dd[0] <= den;
      qq[0] <= '0;
      ss[0] <= XW'(num) >= (XW'(den) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [XW-1:0] dsh;
    logic          take;

    assign dsh  = XW'(dd[k-1]) << (QB - k);
    assign take = XW'(r[k-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        mm[k].valid <= 1'b0;
      end else if (en) begin
        mm[k] <= mm[k-1];
        dd[k] <= dd[k-1];
        ss[k] <= ss[k-1];
        r[k]  <= take ? (r[k-1] - dsh[W-1:0]) : r[k-1];
        qq[k] <= qq[k-1] | (QB'(take) << (QB - k));
      end
    end
  end

  assign quo      = qq[QB];
  assign sat      = ss[QB];
  assign meta_out = mm[QB];

endmodule

`default_nettype wire

FILE: rtl/core/sphk_poly.sv
// ----------------------------------------------------------------------------
// sphk_poly
// Spline pieces f, g from q, then the wide numerator and denominator products.
// ----------------------------------------------------------------------------
`default_nettype none

module sphk_poly import sphk_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [30:0]   q,
  input  logic [92:0]   h3,
  input  sphk_meta_t    meta_in,
  output sphk_meta_t    meta_out,
  output logic [61:0]   kn,
  output logic [93:0]   gxn,
  output logic [93:0]   gyn,
  output logic [124:0]  gden
);

  sphk_meta_t m0, m1, m2, m3, m4, m5, m6;

  logic        near0, near1, near2;
  logic [30:0] u0, u1, u2r, q0, q1, q2;
  logic [61:0] uu1, uuu2;
  logic [30:0] f3, g3;
  logic [61:0] sf4, sg4, sf5;
  logic [62:0] pxl5, pxh5, pyl5, pyh5, pd0, pd1, pd2;

  logic [30:0] u2w, u3w;
  logic [33:0] f_c, g_c;

  // P0: pick q (near piece) or 2 - q (far piece)
  always_ff @(posedge clk) begin
    if (rst) begin
      m0.valid <= 1'b0;
    end else if (en) begin
      m0    <= meta_in;
      q0    <= q;
      near0 <= {1'b0, q} < ONE_Q30;
      u0    <= ({1'b0, q} < ONE_Q30) ? q : 31'(TWO_Q30 - {1'b0, q});
    end
  end

  // P1: u^2
  always_ff @(posedge clk) begin
    if (rst) begin
      m1.valid <= 1'b0;
    end else if (en) begin
      m1    <= m0;
      q1    <= q0;
      near1 <= near0;
      u1    <= u0;
      uu1   <= {31'd0, u0} * {31'd0, u0};
    end
  end

  assign u2w = uu1[60:30];

  // P2: u^3
  always_ff @(posedge clk) begin
    if (rst) begin
      m2.valid <= 1'b0;
    end else if (en) begin
      m2    <= m1;
      q2    <= q1;
      near2 <= near1;
      u2r   <= u2w;
      uuu2  <= {31'd0, u2w} * {31'd0, u1};
    end
  end

  assign u3w = uuu2[60:30];

  always_comb begin
    if (near2) begin
      f_c = 34'(ONE_Q30) + ((34'(u3w) * 34'd3) >> 2) - ((34'(u2r) * 34'd3) >> 1);
      g_c = 34'(q2) * 34'd3 - ((34'(u2r) * 34'd9) >> 2);
    end else begin
      f_c = 34'(u3w) >> 2;
      g_c = (34'(u2r) * 34'd3) >> 2;
    end
  end

  // P3: f and g
  always_ff @(posedge clk) begin
    if (rst) begin
      m3.valid <= 1'b0;
    end else if (en) begin
      m3 <= m2;
      f3 <= f_c[30:0];
      g3 <= g_c[30:0];
    end
  end

  // P4: sigma scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      m4.valid <= 1'b0;
    end else if (en) begin
      m4  <= m3;
      sf4 <= {31'd0, SIGMA_Q32} * {31'd0, f3};
      sg4 <= {31'd0, SIGMA_Q32} * {31'd0, g3};
    end
  end

  // P5: 31x32 partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      m5.valid <= 1'b0;
    end else if (en) begin
      m5   <= m4;
      sf5  <= sf4;
      pxl5 <= {32'd0, sg4[30:0]}  * {31'd0, m4.ax};
      pxh5 <= {32'd0, sg4[61:31]} * {31'd0, m4.ax};
      pyl5 <= {32'd0, sg4[30:0]}  * {31'd0, m4.ay};
      pyh5 <= {32'd0, sg4[61:31]} * {31'd0, m4.ay};
      pd0  <= {32'd0, h3[30:0]}   * {31'd0, m4.rlen};
      pd1  <= {32'd0, h3[61:31]}  * {31'd0, m4.rlen};
      pd2  <= {32'd0, h3[92:62]}  * {31'd0, m4.rlen};
    end
  end

  // P6: partial product sums
  always_ff @(posedge clk) begin
    if (rst) begin
      m6.valid <= 1'b0;
    end else if (en) begin
      m6   <= m5;
      kn   <= sf5;
      gxn  <= (94'(pxh5) << 31) + 94'(pxl5);
      gyn  <= (94'(pyh5) << 31) + 94'(pyl5);
      gden <= (125'(pd2) << 62) + (125'(pd1) << 31) + 125'(pd0);
    end
  end

  assign meta_out = m6;

endmodule

`default_nettype wire

FILE: rtl/core/sph_cubic_spline_kernel_unit.sv
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel_unit
// 2D cubic spline SPH kernel W and gradient from a displacement (dx, dy).
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+------------------------------------
//  disp     | in  | valid/ready   | dx, dy (signed Q.FRAC_BITS)
//  kern     | out | valid/ready   | kernel_value, grad_x, grad_y
//  cfg      | in  | cfg_wr_en     | cfg_wr_data = smoothing length h
//
//  One word per cycle while no stall holds the pipe; 3 front stages, 32 sqrt
//  stages, 32 stages for q = dist/h, 7 polynomial/product stages, 32 stages
//  for the final divides, 1 output register. The long dividers set the depth.
//  Reset (rst, sync) clears all valid bits and sets h to 1.0 (65536).
//  The whole pipe advances when the output register is empty or taken;
//  a stall freezes every stage, nothing is dropped or repeated.
//  h2 follows h through one register, h3 through h3lo/h3hi and then h3.
// ----------------------------------------------------------------------------
`default_nettype none

module sph_cubic_spline_kernel_unit import sphk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sphk_disp_if.sink         disp,
  sphk_kern_if.source       kern,
  input  logic              cfg_wr_en,
  input  logic [H_W-1:0]    cfg_wr_data
);

`include "sph_cubic_spline_kernel_unit_assert.svh"

  // kernel: floor(S f 2^(3F) / (2^62 h^2)); shift goes on num or den
  localparam int KSP = (3 * FRAC_BITS > 62) ? 3 * FRAC_BITS - 62 : 0;
  localparam int KSN = (3 * FRAC_BITS < 62) ? 62 - 3 * FRAC_BITS : 0;
  localparam int KW  = 62 + KSP + KSN;
  // gradient: floor(S g |d| 2^(4F) / (2^62 h^3 dist))
  localparam int GSP = (4 * FRAC_BITS > 62) ? 4 * FRAC_BITS - 62 : 0;
  localparam int GSN = (4 * FRAC_BITS < 62) ? 62 - 4 * FRAC_BITS : 0;
  localparam int GW  = 125 + GSP + GSN;

  logic en;

  // smoothing length and its powers; user must change h only with pipe empty (block does not enforce it)
  logic [H_W-1:0] h;
  logic [61:0]    h2;
  logic [61:0]    h3lo, h3hi;
  logic [92:0]    h3;

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= H_W'(65536);
    end else if (cfg_wr_en) begin
      h <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    h2   <= {31'd0, h} * {31'd0, h};
    h3lo <= {31'd0, h2[30:0]}  * {31'd0, h};
    h3hi <= {31'd0, h2[61:31]} * {31'd0, h};
    h3   <= (93'(h3hi) << 31) + 93'(h3lo);
  end

  // ---------------------------------------------------------------- front end
  logic [31:0] dx_u, dy_u;
  sphk_meta_t  m0_next, m0, m1, m2_next, m2;
  logic [63:0] sqx, sqy, d2_c, d2_r;

  assign dx_u = disp.dx;
  assign dy_u = disp.dy;

  always_comb begin
    m0_next         = '0;
    m0_next.valid   = disp.valid;
    m0_next.neg_x   = dx_u[31];
    m0_next.neg_y   = dy_u[31];
    m0_next.ax      = dx_u[31] ? (~dx_u + 32'd1) : dx_u;
    m0_next.ay      = dy_u[31] ? (~dy_u + 32'd1) : dy_u;
  end

  // stage 0: accept and take magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      m0.valid <= 1'b0;
    end else if (en) begin
      m0 <= m0_next;
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      m1.valid <= 1'b0;
    end else if (en) begin
      m1  <= m0;
      sqx <= {32'd0, m0.ax} * {32'd0, m0.ax};
      sqy <= {32'd0, m0.ay} * {32'd0, m0.ay};
    end
  end

  assign d2_c = sqx + sqy;

  // support test q >= 2 (h = 0 lands here too)
  always_comb begin
    m2_next         = m1;
    m2_next.outside = d2_c >= {h2, 2'b00};
  end

  // stage 2: |r|^2 and the support flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m2.valid <= 1'b0;
    end else if (en) begin
      m2   <= m2_next;
      d2_r <= d2_c;
    end
  end

  // ---------------------------------------------------------------- distance
  sphk_meta_t m_sq, m_q, m_p, m_d;

  sphk_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rad      (d2_r),
    .meta_in  (m2),
    .meta_out (m_sq)
  );

  // q = dist * 2^30 / h in Q30
  logic [Q_BITS-1:0] q_w;

  sphk_div #(.W(62), .QB(Q_BITS)) u_qdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      ({m_sq.rlen, 30'd0}),
    .den      (62'(h)),
    .meta_in  (m_sq),
    .meta_out (m_q),
    .quo      (q_w),
    .sat      ()
  );

  // ---------------------------------------------------------------- spline
  logic [61:0]  kn;
  logic [93:0]  gxn, gyn;
  logic [124:0] gden;

  sphk_poly u_poly (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .q        (q_w),
    .h3       (h3),
    .meta_in  (m_q),
    .meta_out (m_p),
    .kn       (kn),
    .gxn      (gxn),
    .gyn      (gyn),
    .gden     (gden)
  );

  // ---------------------------------------------------------------- divides
  logic [Q_BITS-1:0] kq, gxq, gyq;
  logic              ksat, gxsat, gysat;
  logic [KW-1:0]     k_num, k_den;
  logic [GW-1:0]     gx_num, gy_num, g_den;

  assign k_num  = KW'(kn) << KSP;
  assign k_den  = KW'(h2) << KSN;
  assign gx_num = GW'(gxn) << GSP;
  assign gy_num = GW'(gyn) << GSP;
  assign g_den  = GW'(gden) << GSN;

  sphk_div #(.W(KW), .QB(Q_BITS)) u_kdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (k_num),
    .den      (k_den),
    .meta_in  (m_p),
    .meta_out (m_d),
    .quo      (kq),
    .sat      (ksat)
  );

  sphk_div #(.W(GW), .QB(Q_BITS)) u_gxdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (gx_num),
    .den      (g_den),
    .meta_in  (m_p),
    .meta_out (),
    .quo      (gxq),
    .sat      (gxsat)
  );

  sphk_div #(.W(GW), .QB(Q_BITS)) u_gydiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (gy_num),
    .den      (g_den),
    .meta_in  (m_p),
    .meta_out (),
    .quo      (gyq),
    .sat      (gysat)
  );

  // ---------------------------------------------------------------- output
  // gradient points against r: negative d gives a positive component;
  // magnitude caps at 2^31, which only the negative side can show
  function automatic logic [31:0] grad_word(input logic neg, input logic [30:0] mag,
                                            input logic ovf, input logic zero);
    logic [31:0] w;
    if (zero) begin
      w = 32'd0;
    end else if (neg) begin
      w = ovf ? 32'h7FFF_FFFF : {1'b0, mag};
    end else begin
      w = ovf ? 32'h8000_0000 : (~{1'b0, mag} + 32'd1);
    end
    return w;
  endfunction

  logic        gzero;
  logic        kvalid;
  logic [30:0] kval;
  logic [31:0] gx, gy;

  assign gzero = m_d.outside || (m_d.rlen == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      kvalid <= 1'b0;
    end else if (en) begin
      kvalid <= m_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kval <= m_d.outside ? 31'd0 : (ksat ? 31'h7FFF_FFFF : kq);
      gx   <= grad_word(m_d.neg_x, gxq, gxsat, gzero);
      gy   <= grad_word(m_d.neg_y, gyq, gysat, gzero);
    end
  end

  assign en                = !kvalid || kern.ready;
  assign disp.ready        = en;
  assign kern.valid        = kvalid;
  assign kern.kernel_value = kval;
  assign kern.grad_x       = gx;
  assign kern.grad_y       = gy;

  // ---------------------------------------------------------------- checks
  `SPHK_ASSERT_NEXT(a_accept_enters, clk, rst, disp.valid && disp.ready, m0.valid, "accepted word lost at entry")
  `SPHK_ASSERT_NEXT(a_stall_freezes, clk, rst, !en, $stable(m2) && $stable(d2_r), "front stage moved during stall")
  `SPHK_ASSERT_NEXT(a_outside_zero, clk, rst, en && m_d.valid && m_d.outside, kern.kernel_value == 31'd0 && kern.grad_x == 32'sd0 && kern.grad_y == 32'sd0, "nonzero result outside support")
  `SPHK_ASSERT_NOW(a_ready_when_empty, clk, rst, !kern.valid, disp.ready, "input stalled with empty output")

endmodule

`default_nettype wire

FILE: sim/sph_cubic_spline_kernel_unit_tb.sv
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel_unit_tb
// Drives displacement words into the SPH kernel unit under several
// smoothing lengths, predicts W and its gradient with exact wide integer
// math, and checks every result word in order, with random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sph_cubic_spline_kernel_unit_tb;
  import sphk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int F         = FRAC_BITS_DEF;
  localparam int WDOG_MAX  = 3000;   // cycles with no word moving
  localparam int PIPE_WAIT = 120;    // longer than the pipeline latency
  localparam int HOLD_LEN  = 300;    // long receiver hold, deeper than the pipe

  typedef struct packed {
    logic [30:0] kv;
    logic [31:0] gx;
    logic [31:0] gy;
  } kern_word_t;

  typedef struct {
    logic [30:0]  h;
    logic [31:0]  dx;
    logic [31:0]  dy;
    bit           known;
    kern_word_t   val;
  } disp_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic              cfg_wr_en   = 1'b0;
  logic [H_W-1:0]    cfg_wr_data = '0;

  sphk_disp_if disp ();
  sphk_kern_if kern ();

  sph_cubic_spline_kernel_unit dut (
    .clk         (clk),
    .rst         (rst),
    .disp        (disp),
    .kern        (kern),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  kern_word_t  kern_expected[$];   // predicted words, oldest first
  disp_row_t   rows[$];            // directed stimulus table
  logic [30:0] cur_h = 31'd65536;  // mirror of the h register
  int          errors = 0;
  int          wdog = 0;
  bit          src_idle = 1'b1;    // random gaps on the sender
  bit          snk_idle = 1'b1;    // random stalls on the receiver
  bit          hold_req = 1'b0;    // one long receiver hold-off

  // --------------------------------------------------------------------------
  // Predictor. Final products kept exact in 256 bits, so past the Q30 spline
  // terms the only rounding is the floor of each divide, same as the spec'd math.
  // --------------------------------------------------------------------------
  function automatic logic [63:0] sat_div(logic [255:0] num, logic [255:0] den,
                                          logic [63:0] maxv);
    logic [255:0] quo;
    quo = num / den;
    return (quo > 256'(maxv)) ? maxv : quo[63:0];
  endfunction

  // one gradient component: |g| scaled by |d|/(h^3 |r|), sign opposite to d
  function automatic logic [31:0] grad_part(logic [63:0] g, logic [65:0] a,
                                            logic neg, logic [65:0] hh,
                                            logic [65:0] rlen);
    logic [255:0] num, den;
    logic [63:0]  mag;
    int           sh;
    sh  = 4 * F - 62;
    num = 256'(SIGMA_Q32) * 256'(g) * 256'(a);
    den = 256'(hh) * 256'(hh) * 256'(hh) * 256'(rlen);
    if (sh >= 0) num = num << sh;
    else         den = den << (-sh);
    mag = sat_div(num, den, 64'h8000_0000);
    if (neg) return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    return 32'd0 - mag[31:0];
  endfunction

  function automatic kern_word_t kernel_of(logic [30:0] h, logic [31:0] xr,
                                           logic [31:0] yr);
    logic [65:0]  ax, ay, d2, hh, rlen, cand;
    logic [63:0]  q, q2, q3, t, t2, t3, f, g;
    logic [255:0] num, den;
    kern_word_t   w;
    int           sh;
    int           i;
    w = '0;
    if (h == 0) return w;               // zero h: everything zero
    ax = xr[31] ? (66'd1 << 32) - 66'(xr) : 66'(xr);
    ay = yr[31] ? (66'd1 << 32) - 66'(yr) : 66'(yr);
    hh = 66'(h);
    d2 = ax * ax + ay * ay;
    if (d2 >= 66'd4 * hh * hh) return w; // q >= 2: outside support
    rlen = '0;
    for (i = 31; i >= 0; i--) begin
      cand = rlen | (66'd1 << i);
      if (cand * cand <= d2) rlen = cand;
    end
    q = 64'((rlen << 30) / hh);
    if (q < 64'(ONE_Q30)) begin
      q2 = (q * q) >> 30;
      q3 = (q2 * q) >> 30;
      f  = 64'(ONE_Q30) + ((64'd3 * q3) >> 2) - ((64'd3 * q2) >> 1);
      g  = 64'd3 * q - ((64'd9 * q2) >> 2);
    end else begin
      t  = 64'(TWO_Q30) - q;
      t2 = (t * t) >> 30;
      t3 = (t2 * t) >> 30;
      f  = t3 >> 2;
      g  = (64'd3 * t2) >> 2;
    end
    sh  = 3 * F - 62;
    num = 256'(SIGMA_Q32) * 256'(f);
    den = 256'(hh) * 256'(hh);
    if (sh >= 0) num = num << sh;
    else         den = den << (-sh);
    w.kv = 31'(sat_div(num, den, 64'h7FFF_FFFF));
    if (rlen != 0) begin              // zero displacement leaves grad at 0
      w.gx = grad_part(g, ax, xr[31], hh, rlen);
      w.gy = grad_part(g, ay, yr[31], hh, rlen);
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: drive at negedge, accept at posedge when valid && ready.
  // valid stays high between back-to-back words.
  // --------------------------------------------------------------------------
  task automatic send_word(logic [31:0] dx, logic [31:0] dy, bit known,
                           kern_word_t val);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      disp.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    disp.valid = 1'b1;
    disp.dx    = dx;
    disp.dy    = dy;
    do @(posedge clk); while (!disp.ready);
    kern_expected.push_back(known ? val : kernel_of(cur_h, dx, dy));
    @(negedge clk);
  endtask

  // wait for the pipe to empty, then write h while idle
  task automatic write_h(logic [30:0] h);
    disp.valid = 1'b0;
    while (kern_expected.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = h;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cur_h       = h;
    repeat (4) @(negedge clk);        // let h^2, h^3 settle
  endtask

  task automatic add_row(logic [30:0] h, logic [31:0] dx, logic [31:0] dy,
                         bit known, kern_word_t val);
    disp_row_t r;
    r.h = h; r.dx = dx; r.dy = dy; r.known = known; r.val = val;
    rows.push_back(r);
  endtask

  // random phase: mostly displacements inside ~2.25 h, the rest full range
  task automatic run_random(logic [30:0] h, int n, bit idle, bit hold);
    logic [63:0] span, mag;
    logic [31:0] v[2];
    int          k, j;
    write_h(h);
    src_idle = idle;
    snk_idle = idle;
    span = 64'(h) * 2 + 64'(h) / 4 + 1;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    for (k = 0; k < n; k++) begin
      if (hold && k == 20) hold_req = 1'b1;
      for (j = 0; j < 2; j++) begin
        if ($urandom_range(0, 9) < 7) begin
          mag  = 64'($urandom) % (span + 1);
          v[j] = $urandom_range(0, 1) ? 32'd0 - mag[31:0] : mag[31:0];
        end else begin
          v[j] = $urandom;
        end
      end
      if ($urandom_range(0, 49) == 0) v = '{32'd0, 32'd0};
      send_word(v[0], v[1], 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready changes at negedge, bursts of stall, plus one long hold.
  // --------------------------------------------------------------------------
  initial begin
    kern.ready = 1'b0;
    forever begin
      if (hold_req) begin
        kern.ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else if (snk_idle && $urandom_range(0, 3) == 0) begin
        kern.ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        kern.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // result checker: compare each word with the oldest prediction
  always @(posedge clk) begin
    kern_word_t e;
    if (!rst && kern.valid && kern.ready) begin
      if (kern_expected.size() == 0) begin
        $error("unexpected result word: kv=%0d gx=%0d gy=%0d",
               kern.kernel_value, kern.grad_x, kern.grad_y);
        errors++;
      end else begin
        e = kern_expected.pop_front();
        if (kern.kernel_value !== e.kv) begin
          $error("kernel_value: expected %0d, got %0d", e.kv, kern.kernel_value);
          errors++;
        end
        if (kern.grad_x !== e.gx) begin
          $error("grad_x: expected %0d, got %0d", $signed(e.gx), kern.grad_x);
          errors++;
        end
        if (kern.grad_y !== e.gy) begin
          $error("grad_y: expected %0d, got %0d", $signed(e.gy), kern.grad_y);
          errors++;
        end
      end
    end
  end

  // watchdog: too long with no word moving ends the run
  always @(posedge clk) begin
    if (rst || (disp.valid && disp.ready) || (kern.valid && kern.ready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("sph_cubic_spline_kernel_unit_tb failed");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    kern_word_t zero_w, w;
    int         k;
    disp.valid = 1'b0;
    disp.dx    = '0;
    disp.dy    = '0;
    zero_w     = '0;

    // directed table, grouped by h so each group needs one write
    add_row(31'd0, 32'd0, 32'd0, 1'b1, zero_w);           // zero h
    add_row(31'd0, 32'd100, -32'sd5, 1'b1, zero_w);
    w = '{kv: 31'h7FFF_FFFF, gx: 32'd0, gy: 32'd0};       // tiny h saturates W
    add_row(31'd1, 32'd0, 32'd0, 1'b1, w);
    add_row(31'd1, 32'd1, 32'd0, 1'b0, zero_w);           // q = 1 exactly
    add_row(31'd1, -32'sd1, 32'd1, 1'b0, zero_w);
    add_row(31'd1, 32'd2, 32'd0, 1'b1, zero_w);           // q = 2: outside
    w = '{kv: 31'd29801, gx: 32'd0, gy: 32'd0};           // h = 1.0, r = 0
    add_row(31'd65536, 32'd0, 32'd0, 1'b1, w);
    add_row(31'd65536, 32'd65536, 32'd0, 1'b0, zero_w);
    add_row(31'd65536, -32'sd65536, 32'd0, 1'b0, zero_w);
    add_row(31'd65536, 32'd131071, 32'd0, 1'b0, zero_w);
    add_row(31'd65536, 32'd0, -32'sd131071, 1'b0, zero_w);
    add_row(31'd65536, 32'd131072, 32'd0, 1'b1, zero_w);
    add_row(31'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, zero_w);
    add_row(31'd65536, 32'h8000_0000, 32'h8000_0000, 1'b1, zero_w);
    add_row(31'd65536, 32'h8000_0000, 32'd0, 1'b1, zero_w);
    add_row(31'd65536, 32'd1, 32'd1, 1'b0, zero_w);
    add_row(31'd65536, -32'sd1, -32'sd1, 1'b0, zero_w);
    add_row(31'd65536, 32'd46341, -32'sd46341, 1'b0, zero_w);
    add_row(31'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, zero_w);   // largest h
    add_row(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b0, zero_w);
    add_row(31'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0, zero_w);
    add_row(31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, zero_w);
    add_row(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0, zero_w);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // row with h == 0 first, so every group gets its own write
    for (k = 0; k < rows.size(); k++) begin
      if (k == 0 || rows[k].h != cur_h) write_h(rows[k].h);
      send_word(rows[k].dx, rows[k].dy, rows[k].known, rows[k].val);
    end

    run_random(31'd65536, 200, 1'b1, 1'b1);              // with long hold
    run_random(31'd1, 120, 1'b1, 1'b0);
    run_random(31'h7FFF_FFFF, 150, 1'b1, 1'b0);
    run_random(31'($urandom_range(256, 4096)), 200, 1'b1, 1'b0);
    run_random(31'($urandom_range(4097, 32'h4000_0000)), 150, 1'b1, 1'b0);
    run_random(31'(32'd65536 + $urandom_range(0, 65536)), 130, 1'b0, 1'b0);

    disp.valid = 1'b0;
    while (kern_expected.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    if (kern_expected.size() != 0) errors++;
    if (errors == 0) begin
      $display("sph_cubic_spline_kernel_unit_tb passed");
    end else begin
      $display("sph_cubic_spline_kernel_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
